// ===== design/fbsp_pkg.sv =====
// shared types and constants for the boot sector parser
// byte offsets of the captured fields, step counts of the serial units, sequencer states
// no dependencies
package fbsp_pkg;

   // byte offsets inside the boot sector
   localparam int OFFSET_WIDTH = 6;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SECTOR_LO    = 6'd11;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SECTOR_HI    = 6'd12;
   localparam logic [OFFSET_WIDTH-1:0] OFF_CLUSTER      = 6'd13;
   localparam logic [OFFSET_WIDTH-1:0] OFF_RESERVED_LO  = 6'd14;
   localparam logic [OFFSET_WIDTH-1:0] OFF_RESERVED_HI  = 6'd15;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FAT_COUNT    = 6'd16;
   localparam logic [OFFSET_WIDTH-1:0] OFF_ROOT_LO      = 6'd17;
   localparam logic [OFFSET_WIDTH-1:0] OFF_ROOT_HI      = 6'd18;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ16_LO   = 6'd22;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ16_HI   = 6'd23;
   localparam logic [OFFSET_WIDTH-1:0] OFF_HIDDEN_B0    = 6'd28;
   localparam logic [OFFSET_WIDTH-1:0] OFF_HIDDEN_B1    = 6'd29;
   localparam logic [OFFSET_WIDTH-1:0] OFF_HIDDEN_B2    = 6'd30;
   localparam logic [OFFSET_WIDTH-1:0] OFF_HIDDEN_B3    = 6'd31;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ32_B0   = 6'd36;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ32_B1   = 6'd37;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ32_B2   = 6'd38;
   localparam logic [OFFSET_WIDTH-1:0] OFF_FATSZ32_B3   = 6'd39;
   localparam logic [OFFSET_WIDTH-1:0] OFF_LIMIT        = 6'd40;

   // a directory entry is 32 bytes: shift the entry count by five
   localparam int DIR_ENTRY_SHIFT = 5;

   // serial arithmetic
   localparam int PROD_WIDTH = 40;
   localparam int QUO_WIDTH  = 21;
   localparam int MUL_CNT_WIDTH = 4;
   localparam int DIV_CNT_WIDTH = 5;
   localparam logic [MUL_CNT_WIDTH-1:0] MUL_STEPS = 4'd8;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_STEPS = 5'd21;

   // captured boot sector fields
   typedef struct packed {
      logic [15:0] sec_len;
      logic [7:0]  clus_secs;
      logic [15:0] reserved;
      logic [7:0]  fat_count;
      logic [15:0] root_entries;
      logic [15:0] fat_size_short;
      logic [31:0] hidden;
      logic [31:0] fat_size_long;
   } fbsp_fields_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CALC,
      ST_SUM
   } fbsp_state_type;

endpackage

// ===== design/fbsp_capture.sv =====
// byte offset counter and little-endian field capture registers
// depends on fbsp_pkg
module fbsp_capture (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output fbsp_pkg::fbsp_fields_type fields
);
   import fbsp_pkg::*;

   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   fbsp_fields_type         fields_ff, fields_in;

   // offset counts up to the limit, returns to zero after the last item
   always_comb begin
      offset_in = offset_ff;
      if (byte_accept) begin
         if (last_byte) begin
            offset_in = '0;
         end else if (offset_ff < OFF_LIMIT) begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   // place the incoming byte into the field that owns this offset
   always_comb begin
      fields_in = fields_ff;
      if (byte_accept) begin
         case (offset_ff)
            OFF_SECTOR_LO:   fields_in.sec_len[7:0]         = data_byte;
            OFF_SECTOR_HI:   fields_in.sec_len[15:8]        = data_byte;
            OFF_CLUSTER:     fields_in.clus_secs            = data_byte;
            OFF_RESERVED_LO: fields_in.reserved[7:0]        = data_byte;
            OFF_RESERVED_HI: fields_in.reserved[15:8]       = data_byte;
            OFF_FAT_COUNT:   fields_in.fat_count            = data_byte;
            OFF_ROOT_LO:     fields_in.root_entries[7:0]    = data_byte;
            OFF_ROOT_HI:     fields_in.root_entries[15:8]   = data_byte;
            OFF_FATSZ16_LO:  fields_in.fat_size_short[7:0]  = data_byte;
            OFF_FATSZ16_HI:  fields_in.fat_size_short[15:8] = data_byte;
            OFF_HIDDEN_B0:   fields_in.hidden[7:0]          = data_byte;
            OFF_HIDDEN_B1:   fields_in.hidden[15:8]         = data_byte;
            OFF_HIDDEN_B2:   fields_in.hidden[23:16]        = data_byte;
            OFF_HIDDEN_B3:   fields_in.hidden[31:24]        = data_byte;
            OFF_FATSZ32_B0:  fields_in.fat_size_long[7:0]   = data_byte;
            OFF_FATSZ32_B1:  fields_in.fat_size_long[15:8]  = data_byte;
            OFF_FATSZ32_B2:  fields_in.fat_size_long[23:16] = data_byte;
            OFF_FATSZ32_B3:  fields_in.fat_size_long[31:24] = data_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         fields_ff <= '0;
      end else begin
         offset_ff <= offset_in;
         fields_ff <= fields_in;
      end
   end

   assign fields = fields_ff;

endmodule

// ===== design/fbsp_mul.sv =====
// bit-serial multiply-add: addend + multiplicand * multiplier, one multiplier bit a cycle
// depends on fbsp_pkg
module fbsp_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [15:0]                     addend,
   input  logic [31:0]                     mcand,
   input  logic [7:0]                      mplier,
   output logic [fbsp_pkg::PROD_WIDTH-1:0] product,
   output logic                            done
);
   import fbsp_pkg::*;

   logic [PROD_WIDTH-1:0]    acc_ff, acc_in;
   logic [PROD_WIDTH-1:0]    mcand_ff, mcand_in;
   logic [7:0]               mplier_ff, mplier_in;
   logic [MUL_CNT_WIDTH-1:0] count_ff, count_in;

   // load operands on start, then shift and add one bit per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      if (start) begin
         acc_in    = {{(PROD_WIDTH-16){1'b0}}, addend};
         mcand_in  = {{(PROD_WIDTH-32){1'b0}}, mcand};
         mplier_in = mplier;
         count_in  = '0;
      end else if (count_ff != MUL_STEPS) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[7:1]};
         count_in  = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= MUL_STEPS;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product = acc_ff;
   assign done    = (count_ff == MUL_STEPS);

endmodule

// ===== design/fbsp_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on fbsp_pkg
module fbsp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fbsp_pkg::QUO_WIDTH-1:0] dividend,
   input  logic [15:0]                    divisor,
   output logic [fbsp_pkg::QUO_WIDTH-1:0] quotient,
   output logic                           done
);
   import fbsp_pkg::*;

   logic [QUO_WIDTH-1:0]     quo_ff, quo_in;
   logic [15:0]              rem_ff, rem_in;
   logic [15:0]              divisor_ff, divisor_in;
   logic [DIV_CNT_WIDTH-1:0] count_ff, count_in;
   logic [16:0]              trial;
   logic [16:0]              diff;
   logic                     fits;

   // shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[QUO_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = '0;
      end else if (count_ff != DIV_STEPS) begin
         rem_in   = fits ? diff[15:0] : trial[15:0];
         quo_in   = {quo_ff[QUO_WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DIV_STEPS;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = (count_ff == DIV_STEPS);

endmodule

// ===== design/fat_boot_sector_parser.sv =====
// boot sector parameter block parser, top level
// depends on fbsp_pkg, fbsp_capture, fbsp_mul, fbsp_div
//
// Usage:
//   The req_ channel carries the boot sector one byte per item, first byte at
//   offset zero; req_last_byte marks the final byte of the sector. After the
//   item with req_last_byte set, one result item appears on the rsp_ channel:
//   the sequencer snapshots the captured fields, the bit-serial divider gives
//   the root directory sector count (the 8-step serial multiply for the root
//   directory start runs alongside it), the sequencer sees both units finish
//   and, once the output register is free, does the final add into it.
//   Bytes keep flowing while the result is computed. Only a further byte with
//   req_last_byte set is stalled until the previous result has moved into the
//   output register, so a full 512-byte sector sees no stall unless the
//   receiver holds a result back.
//   The result waits in the output register while rsp_stall is high.
//   Reset clears the byte offset, all captured fields and the sequencer;
//   no result is pending after reset.
module fat_boot_sector_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_fat32,
   output logic [15:0] rsp_bytes_per_sector,
   output logic [7:0]  rsp_sectors_per_cluster,
   output logic [15:0] rsp_rsvd_secs,
   output logic [7:0]  rsp_fat_copies,
   output logic [15:0] rsp_root_entries,
   output logic [31:0] rsp_fat_secs,
   output logic [31:0] rsp_hidden_secs,
   output logic [39:0] rsp_rootdir_start,
   output logic [20:0] rsp_root_dir_sectors,
   output logic [39:0] rsp_data_start,
   output logic        rsp_bad_sec_len
);
   import fbsp_pkg::*;

   fbsp_state_type        state_ff, state_in;
   fbsp_fields_type       live_fields;
   fbsp_fields_type       snap_ff, snap_in;
   logic                  req_accept;
   logic                  out_free;
   logic                  calc_start;
   logic                  out_load;
   logic                  snap_fat32;
   logic [31:0]           snap_spf;
   logic [PROD_WIDTH-1:0] mul_product;
   logic                  mul_done;
   logic [QUO_WIDTH-1:0]  div_dividend;
   logic [QUO_WIDTH-1:0]  div_quotient;
   logic                  div_done;
   logic                  snap_bad;
   logic [QUO_WIDTH-1:0]  root_secs;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  is_fat32_ff;
   logic [15:0]           bytes_per_sector_ff;
   logic [7:0]            sectors_per_cluster_ff;
   logic [15:0]           rsvd_secs_ff;
   logic [7:0]            fat_copies_ff;
   logic [15:0]           root_entries_ff;
   logic [31:0]           fat_secs_ff;
   logic [31:0]           hidden_secs_ff;
   logic [39:0]           rootdir_start_ff;
   logic [20:0]           root_dir_sectors_ff;
   logic [39:0]           data_start_ff;
   logic                  bad_sec_len_ff;

   // input handshake: a new last item waits while a result is in flight
   assign req_stall  = req_last_byte && (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   fbsp_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .fields      (live_fields)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept && req_last_byte) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_CALC;
         ST_CALC: if (mul_done && div_done) state_in = ST_SUM;
         ST_SUM:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      calc_start = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_LOAD: calc_start = 1'b1;
         ST_SUM:  out_load   = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // snapshot of the fields as they stood after the last item
   assign snap_in = calc_start ? live_fields : snap_ff;

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   // volume type chooses the fat size for the multiplier
   always_comb begin
      snap_fat32 = (live_fields.root_entries == 16'd0);
      snap_spf   = snap_fat32 ? live_fields.fat_size_long
                              : {16'd0, live_fields.fat_size_short};
   end

   fbsp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (calc_start),
      .addend  (live_fields.reserved),
      .mcand   (snap_spf),
      .mplier  (live_fields.fat_count),
      .product (mul_product),
      .done    (mul_done)
   );

   assign div_dividend = {live_fields.root_entries, {DIR_ENTRY_SHIFT{1'b0}}};

   fbsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start),
      .dividend (div_dividend),
      .divisor  (live_fields.sec_len),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // zero sector size forces the root directory sector count to zero
   assign snap_bad  = (snap_ff.sec_len == 16'd0);
   assign root_secs = snap_bad ? '0 : div_quotient;

   // output register
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         is_fat32_ff            <= (snap_ff.root_entries == 16'd0);
         bytes_per_sector_ff    <= snap_ff.sec_len;
         sectors_per_cluster_ff <= snap_ff.clus_secs;
         rsvd_secs_ff           <= snap_ff.reserved;
         fat_copies_ff          <= snap_ff.fat_count;
         root_entries_ff        <= snap_ff.root_entries;
         if (snap_ff.root_entries == 16'd0) begin
            fat_secs_ff    <= snap_ff.fat_size_long;
            hidden_secs_ff <= snap_ff.hidden;
         end else begin
            fat_secs_ff    <= {16'd0, snap_ff.fat_size_short};
            hidden_secs_ff <= {16'd0, snap_ff.hidden[15:0]};
         end
         rootdir_start_ff    <= mul_product;
         root_dir_sectors_ff <= root_secs;
         data_start_ff       <= mul_product + {{(PROD_WIDTH-QUO_WIDTH){1'b0}}, root_secs};
         bad_sec_len_ff      <= snap_bad;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_is_fat32            = is_fat32_ff;
   assign rsp_bytes_per_sector    = bytes_per_sector_ff;
   assign rsp_sectors_per_cluster = sectors_per_cluster_ff;
   assign rsp_rsvd_secs           = rsvd_secs_ff;
   assign rsp_fat_copies          = fat_copies_ff;
   assign rsp_root_entries        = root_entries_ff;
   assign rsp_fat_secs            = fat_secs_ff;
   assign rsp_hidden_secs         = hidden_secs_ff;
   assign rsp_rootdir_start       = rootdir_start_ff;
   assign rsp_root_dir_sectors    = root_dir_sectors_ff;
   assign rsp_data_start          = data_start_ff;
   assign rsp_bad_sec_len         = bad_sec_len_ff;

endmodule
